// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that prop holds on every edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that cons holds in the same cycle whenever ante holds
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

// ----- rtl/prq_pkg.sv -----
// Package: types and constants of the priority ready-queue scheduler
`default_nettype none
package prq_pkg;
  localparam int unsigned QueueDepthDef = 16;
  localparam logic [7:0] TimeSliceReset = 8'd4;
  localparam logic [15:0] InitId = 16'd1;
  localparam logic [5:0] InitPrio = 6'd31;
  localparam logic [15:0] FirstFreeId = 16'd2;

  typedef enum logic [2:0] {
    CmdTick = 3'd0, CmdCreate = 3'd1, CmdUnblock = 3'd2, CmdYield = 3'd3,
    CmdBlock = 3'd4, CmdExit = 3'd5, CmdSetPrio = 3'd6, CmdNop = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] thread_id;
    logic [5:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic [15:0] running_id;
    logic [5:0]  running_priority;
    logic [15:0] created_id;
    logic        switched;
    logic        rejected;
    logic [31:0] idle_tick_count;
    logic [31:0] busy_tick_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [5:0]  prio;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/priority_ready_queue_scheduler_core.sv -----
// Preemptive priority scheduler with round robin among equal priorities: top level
// Timing: the sorted-queue walk in prq_queue, one entry moved per cycle, sets how long
// a command takes from one start to the next.
// Throughput: one command at a time; busy stays high through the result strobe.
// Reset: empty queue, thread 1 at priority 31 running, slice limit 4.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module priority_ready_queue_scheduler_core #(
  parameter int unsigned QueueDepth = prq_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire prq_pkg::req_t req_i,
  output logic               done_o,
  output prq_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [7:0]    cfg_data_i
);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef enum logic [7:0] {
    SIdle = 8'b00000001, SDecide = 8'b00000010, SPopWait = 8'b00000100,
    SReins = 8'b00001000, SInsWait = 8'b00010000, SReinsWait = 8'b00100000,
    SCheck = 8'b01000000, SDone = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  prq_pkg::req_t req_q, req_d;
  logic [7:0] slice_cfg_q;
  logic [15:0] cur_id_q, cur_id_d, before_q, before_d, next_id_q, next_id_d;
  logic [15:0] created_q, created_d;
  logic [5:0] cur_pr_q, cur_pr_d;
  logic [7:0] slice_q, slice_d;
  logic [31:0] idle_q, idle_d, busyc_q, busyc_d;
  logic rej_q, rej_d;
  prq_pkg::entry_t saved_q, saved_d;
  logic q_ins, q_pop, q_done;
  prq_pkg::entry_t q_entry, q_head;
  logic [CntW-1:0] q_count;
  logic full;

  prq_queue #(.QueueDepth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .ins_i(q_ins), .pop_i(q_pop), .ins_entry_i(q_entry),
    .done_o(q_done), .head_o(q_head), .count_o(q_count)
  );

  assign full = (q_count == CntW'(QueueDepth));
  assign busy = (state_q != SIdle);
  assign cfg_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q; req_d = req_q; cur_id_d = cur_id_q; cur_pr_d = cur_pr_q;
    before_d = before_q; next_id_d = next_id_q; created_d = created_q;
    slice_d = slice_q; idle_d = idle_q; busyc_d = busyc_q; rej_d = rej_q;
    saved_d = saved_q; q_ins = 1'b0; q_pop = 1'b0; q_entry = saved_q;
    done_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          req_d = req_i; before_d = cur_id_q; created_d = '0; rej_d = 1'b0;
          state_d = SDecide;
        end
      end
      SDecide: begin
        state_d = SDone;
        unique case (prq_pkg::cmd_e'(req_q.command))
          prq_pkg::CmdTick: begin
            if (cur_id_q == '0) idle_d = idle_q + 32'd1;
            else busyc_d = busyc_q + 32'd1;
            slice_d = (slice_q != 8'hFF) ? slice_q + 8'd1 : slice_q;
            if (slice_d >= slice_cfg_q) state_d = SCheck;
          end
          prq_pkg::CmdCreate: begin
            if (full) rej_d = 1'b1;
            else begin
              saved_d = '{id: next_id_q, prio: req_q.priority_req};
              created_d = next_id_q;
              next_id_d = (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
              state_d = SInsWait;
            end
          end
          prq_pkg::CmdUnblock: begin
            if (req_q.thread_id != '0) begin
              if (full) rej_d = 1'b1;
              else begin
                saved_d = '{id: req_q.thread_id, prio: req_q.priority_req};
                state_d = SInsWait;
              end
            end
          end
          prq_pkg::CmdYield: state_d = SCheck;
          prq_pkg::CmdBlock, prq_pkg::CmdExit: begin
            slice_d = '0;
            if (q_count == '0) begin
              cur_id_d = '0; cur_pr_d = '0;
            end else begin
              cur_id_d = q_head.id; cur_pr_d = q_head.prio; saved_d.id = '0;
              q_pop = 1'b1; state_d = SPopWait;
            end
          end
          prq_pkg::CmdSetPrio: begin
            if (cur_id_q != '0) cur_pr_d = req_q.priority_req;
            if (q_count != '0 && q_head.prio > cur_pr_d) state_d = SCheck;
          end
          default: state_d = SDone;
        endcase
        if (state_d == SInsWait) q_ins = 1'b1;
        q_entry = saved_d;
      end
      SInsWait: begin
        // after create insert, preempt if new prio is above current
        if (q_done) begin
          if (req_q.command == prq_pkg::CmdCreate && saved_q.prio > cur_pr_q)
            state_d = SCheck;
          else state_d = SDone;
        end
      end
      SCheck: begin
        // yield
        slice_d = '0;
        state_d = SDone;
        if (cur_id_q == '0) begin
          if (q_count != '0) begin
            cur_id_d = q_head.id; cur_pr_d = q_head.prio; saved_d.id = '0;
            q_pop = 1'b1; state_d = SPopWait;
          end
        end else if (q_count != '0 && cur_pr_q <= q_head.prio) begin
          saved_d = '{id: cur_id_q, prio: cur_pr_q};
          cur_id_d = q_head.id; cur_pr_d = q_head.prio;
          q_pop = 1'b1; state_d = SPopWait;
        end
      end
      SPopWait: begin
        if (q_done) state_d = (saved_q.id != '0) ? SReins : SDone;
      end
      SReins: begin
        q_ins = 1'b1; q_entry = saved_q; state_d = SReinsWait;
      end
      SReinsWait: begin
        if (q_done) state_d = SDone;
      end
      SDone: begin
        done_o = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    rsp_o.running_id = cur_id_q;
    rsp_o.running_priority = cur_pr_q;
    rsp_o.created_id = created_q;
    rsp_o.switched = (cur_id_q != before_q);
    rsp_o.rejected = rej_q;
    rsp_o.idle_tick_count = idle_q;
    rsp_o.busy_tick_count = busyc_q;
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; saved_q <= saved_d; created_q <= created_d;
    before_q <= before_d; rej_q <= rej_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      slice_cfg_q <= prq_pkg::TimeSliceReset;
      cur_id_q <= prq_pkg::InitId;
      cur_pr_q <= prq_pkg::InitPrio;
      next_id_q <= prq_pkg::FirstFreeId;
      slice_q <= '0; idle_q <= '0; busyc_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) slice_cfg_q <= cfg_data_i;
      cur_id_q <= cur_id_d; cur_pr_q <= cur_pr_d; next_id_q <= next_id_d;
      slice_q <= slice_d; idle_q <= idle_d; busyc_q <= busyc_d;
    end
  end

  `ASSERT_IMPL(a_done_from_done_state, clk_i, rst_ni, done_o, busy, "strobe while idle")
  `ASSERT_IMPL(a_idle_prio_zero, clk_i, rst_ni, done_o && rsp_o.running_id == 16'd0,
    rsp_o.running_priority == 6'd0, "idle thread has nonzero priority")
  `ASSERT_IMPL(a_created_not_rejected, clk_i, rst_ni, done_o && rsp_o.rejected,
    rsp_o.created_id == 16'd0, "rejected create reports an id")
endmodule
`default_nettype wire

// ----- rtl/prq_queue.sv -----
// Sorted ready queue: one entry moved per cycle by a shared shift/compare step
`default_nettype none
module prq_queue #(
  parameter int unsigned QueueDepth = prq_pkg::QueueDepthDef,
  localparam int unsigned IdxW = $clog2(QueueDepth),
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            ins_i,
  input  wire logic            pop_i,
  input  wire prq_pkg::entry_t ins_entry_i,
  output logic                 done_o,
  output prq_pkg::entry_t      head_o,
  output logic [CntW-1:0]      count_o
);
  typedef enum logic [3:0] {
    QIdle = 4'b0001, QSearch = 4'b0010, QShift = 4'b0100, QPop = 4'b1000
  } qstate_e;

  qstate_e state_q, state_d;
  prq_pkg::entry_t mem_q [QueueDepth];
  prq_pkg::entry_t head_q, rd_q;
  logic [CntW-1:0] count_q, count_d, ptr_q, ptr_d;
  logic we;
  logic [IdxW-1:0] waddr;
  prq_pkg::entry_t wdata;
  logic [IdxW-1:0] raddr;

  assign head_o = head_q;
  assign count_o = count_q;

  // ptr walks the queue; rd_q is the registered read of raddr (the entry at ptr when popping)
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d = ptr_q;
    we = 1'b0;
    waddr = ptr_q[IdxW-1:0];
    wdata = ins_entry_i;
    raddr = ptr_q[IdxW-1:0];
    done_o = 1'b0;
    unique case (state_q)
      QIdle: begin
        if (ins_i) begin
          // search from the tail backward: shift while entry prio < new prio
          ptr_d = count_q;
          raddr = IdxW'(count_q - CntW'(1));
          state_d = QSearch;
        end else if (pop_i) begin
          ptr_d = CntW'(1);
          raddr = IdxW'(1);
          state_d = QPop;
        end
      end
      QSearch: begin
        // ptr is the free slot; rd_q is entry ptr-1
        if (ptr_q != '0 && rd_q.prio < ins_entry_i.prio) begin
          we = 1'b1;
          waddr = ptr_q[IdxW-1:0];
          wdata = rd_q;
          ptr_d = ptr_q - CntW'(1);
          raddr = IdxW'(ptr_q - CntW'(2));
        end else begin
          we = 1'b1;
          waddr = ptr_q[IdxW-1:0];
          wdata = ins_entry_i;
          count_d = count_q + CntW'(1);
          state_d = QShift;
          ptr_d = '0;
          raddr = '0;
        end
      end
      QShift: begin
        // reload head after change
        raddr = '0;
        done_o = 1'b1;
        state_d = QIdle;
      end
      QPop: begin
        if (ptr_q < count_q) begin
          we = 1'b1;
          waddr = IdxW'(ptr_q - CntW'(1));
          wdata = rd_q;
          ptr_d = ptr_q + CntW'(1);
          raddr = IdxW'(ptr_q + CntW'(1));
        end else begin
          count_d = count_q - CntW'(1);
          ptr_d = '0;
          raddr = '0;
          state_d = QShift;
        end
      end
      default: state_d = QIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
    if (state_q == QShift) head_q <= mem_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= QIdle;
      count_q <= '0;
      ptr_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q <= ptr_d;
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the priority ready-queue scheduler: directed, full-queue, slice, random, pressure and refill tests
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = prq_pkg::QueueDepthDef;
  localparam int unsigned SettleCycles = 2 * Depth + 12;
  localparam longint unsigned CycleLimit = 64'd1_000_000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  prq_pkg::req_t   req_i = '0;
  logic            done_o;
  prq_pkg::rsp_t   rsp_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [7:0]      cfg_data_i = 8'd0;

  priority_ready_queue_scheduler_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Scheduler mirror
  logic [15:0] rq_id [Depth];
  logic [5:0]  rq_pr [Depth];
  int unsigned rq_count = 0;
  logic [15:0] run_id = prq_pkg::InitId;
  logic [5:0]  run_pr = prq_pkg::InitPrio;
  logic [7:0]  slice_used = 8'd0;
  logic [15:0] alloc_id = prq_pkg::FirstFreeId;
  logic [31:0] idle_seen = 32'd0;
  logic [31:0] busy_ticks = 32'd0;
  logic [7:0]  slice_limit = prq_pkg::TimeSliceReset;

  prq_pkg::rsp_t   pending_rsp[$];
  int unsigned     fail_count = 0;
  longint unsigned cycle_count = 0;
  bit              gaps_on = 1'b1;

  function automatic bit rq_insert(logic [15:0] id, logic [5:0] pr);
    int unsigned pos;
    if (rq_count >= Depth) return 1'b0;
    pos = 0;
    while (pos < rq_count && rq_pr[pos] >= pr) pos++;
    for (int unsigned i = rq_count; i > pos; i--) begin
      rq_id[i] = rq_id[i-1];
      rq_pr[i] = rq_pr[i-1];
    end
    rq_id[pos] = id;
    rq_pr[pos] = pr;
    rq_count++;
    return 1'b1;
  endfunction

  function automatic void rq_pop_to_run();
    if (rq_count == 0) begin
      run_id = 16'd0;
      run_pr = 6'd0;
      return;
    end
    run_id = rq_id[0];
    run_pr = rq_pr[0];
    for (int unsigned i = 1; i < rq_count; i++) begin
      rq_id[i-1] = rq_id[i];
      rq_pr[i-1] = rq_pr[i];
    end
    rq_count--;
  endfunction

  function automatic void rq_yield();
    logic [15:0] id;
    logic [5:0] pr;
    if (run_id == 16'd0) begin
      rq_pop_to_run();
    end else if (rq_count > 0 && run_pr <= rq_pr[0]) begin
      id = run_id;
      pr = run_pr;
      rq_pop_to_run();
      void'(rq_insert(id, pr));
    end
    slice_used = 8'd0;
  endfunction

  function automatic prq_pkg::rsp_t schedule(prq_pkg::req_t r);
    prq_pkg::rsp_t o;
    logic [15:0] was_id;
    was_id = run_id;
    o = '0;
    case (prq_pkg::cmd_e'(r.command))
      prq_pkg::CmdTick: begin
        if (run_id == 16'd0) idle_seen++;
        else busy_ticks++;
        if (slice_used != 8'd255) slice_used++;
        if (slice_used >= slice_limit) rq_yield();
      end
      prq_pkg::CmdCreate: begin
        if (rq_insert(alloc_id, r.priority_req)) begin
          o.created_id = alloc_id;
          alloc_id++;
          if (alloc_id == 16'd0) alloc_id = 16'd1;
          if (r.priority_req > run_pr) rq_yield();
        end else begin
          o.rejected = 1'b1;
        end
      end
      prq_pkg::CmdUnblock: begin
        if (r.thread_id != 16'd0 && !rq_insert(r.thread_id, r.priority_req))
          o.rejected = 1'b1;
      end
      prq_pkg::CmdYield: rq_yield();
      prq_pkg::CmdBlock, prq_pkg::CmdExit: begin
        rq_pop_to_run();
        slice_used = 8'd0;
      end
      prq_pkg::CmdSetPrio: begin
        if (run_id != 16'd0) run_pr = r.priority_req;
        if (rq_count > 0 && rq_pr[0] > run_pr) rq_yield();
      end
      default: ;
    endcase
    o.running_id = run_id;
    o.running_priority = run_pr;
    o.switched = (run_id != was_id);
    o.idle_tick_count = idle_seen;
    o.busy_tick_count = busy_ticks;
    return o;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Compare every strobed result with the oldest prediction
  always @(posedge clk_i) begin
    prq_pkg::rsp_t e;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("result strobe with no command outstanding");
        fail_count++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("running_id", 32'(e.running_id), 32'(rsp_o.running_id));
        check_field("running_priority", 32'(e.running_priority),
                    32'(rsp_o.running_priority));
        check_field("created_id", 32'(e.created_id), 32'(rsp_o.created_id));
        check_field("switched", 32'(e.switched), 32'(rsp_o.switched));
        check_field("rejected", 32'(e.rejected), 32'(rsp_o.rejected));
        check_field("idle_tick_count", e.idle_tick_count, rsp_o.idle_tick_count);
        check_field("busy_tick_count", e.busy_tick_count, rsp_o.busy_tick_count);
      end
    end
  end

  // Start is left high after a transfer; any pause lowers it first
  task automatic send_cmd(prq_pkg::cmd_e c, logic [15:0] tid, logic [5:0] pr);
    prq_pkg::req_t r;
    r.command = c;
    r.thread_id = tid;
    r.priority_req = pr;
    if (gaps_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_rsp.push_back(schedule(r));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_slice(logic [7:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    slice_limit = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random();
    int unsigned k;
    logic [15:0] tid;
    logic [5:0] pr;
    k = $urandom_range(99);
    tid = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
    pr = ($urandom_range(1) == 0) ? 6'($urandom_range(28, 34)) : 6'($urandom);
    if (k < 30) send_cmd(prq_pkg::CmdTick, tid, pr);
    else if (k < 45) send_cmd(prq_pkg::CmdCreate, tid, pr);
    else if (k < 60) send_cmd(prq_pkg::CmdUnblock, tid, pr);
    else if (k < 70) send_cmd(prq_pkg::CmdYield, tid, pr);
    else if (k < 76) send_cmd(prq_pkg::CmdBlock, tid, pr);
    else if (k < 82) send_cmd(prq_pkg::CmdExit, tid, pr);
    else if (k < 96) send_cmd(prq_pkg::CmdSetPrio, tid, pr);
    else send_cmd(prq_pkg::CmdNop, tid, pr);
  endtask

  task automatic test_directed();
    send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdSetPrio, 16'hFFFF, 6'h3F);
    send_cmd(prq_pkg::CmdCreate, 16'hAAAA, 6'h00);
    send_cmd(prq_pkg::CmdCreate, 16'h5555, 6'h3F);
    send_cmd(prq_pkg::CmdUnblock, 16'h0000, 6'h3F);
    send_cmd(prq_pkg::CmdUnblock, 16'hFFFF, 6'h3F);
    send_cmd(prq_pkg::CmdUnblock, 16'h8001, 6'h2A);
    send_cmd(prq_pkg::CmdYield, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdSetPrio, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdNop, 16'hFFFF, 6'h3F);
    send_cmd(prq_pkg::CmdBlock, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdExit, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdExit, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdExit, 16'h0000, 6'h00);
    // empty ready queue: priority write applies to the running thread, ticks go to the busy counter
    send_cmd(prq_pkg::CmdSetPrio, 16'h0000, 6'h15);
    send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdYield, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdUnblock, 16'h0007, 6'h10);
    send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdCreate, 16'h0000, 6'h3F);
    send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
  endtask

  task automatic test_full_queue();
    while (rq_count < Depth)
      send_cmd(prq_pkg::CmdUnblock, 16'($urandom_range(1, 65535)),
               6'($urandom_range(5, 8)));
    send_cmd(prq_pkg::CmdCreate, 16'h0000, 6'h3F);
    send_cmd(prq_pkg::CmdUnblock, 16'h1234, 6'h3F);
    send_cmd(prq_pkg::CmdSetPrio, 16'h0000, 6'h05);
    send_cmd(prq_pkg::CmdYield, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
  endtask

  task automatic test_slice_settings();
    write_slice(8'd0);
    repeat (6) send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
    write_slice(8'd1);
    repeat (6) send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
    write_slice(8'd255);
    repeat (270) send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
  endtask

  task automatic test_random();
    for (int seg = 0; seg < 4; seg++) begin
      write_slice((seg == 3) ? prq_pkg::TimeSliceReset : 8'($urandom_range(1, 12)));
      gaps_on = (seg != 1);
      repeat (180) send_random();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_pressure();
    repeat (10) send_random();
    drain();
    repeat (10) send_random();
  endtask

  task automatic test_empty_refill();
    gaps_on = 1'b0;
    drain();
    while (rq_count > 0) send_cmd(prq_pkg::CmdBlock, 16'h0000, 6'h00);
    send_cmd(prq_pkg::CmdBlock, 16'h0000, 6'h00);
    repeat (3) send_cmd(prq_pkg::CmdCreate, 16'h0000, 6'h01);
    send_cmd(prq_pkg::CmdTick, 16'h0000, 6'h00);
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_queue();
    test_slice_settings();
    test_random();
    test_pressure();
    test_empty_refill();
    drain();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
